// ===== rtl/ibm_dma_pkg.sv =====
// ibm_dma_pkg: constants, codes and result type for the bus-master ide dma controller
// no dependencies
package ibm_dma_pkg;

  localparam int unsigned NumChannels = 2;
  localparam int unsigned MaxTransfer = 65536;

  typedef enum logic [2:0] {
    KIND_REG_WRITE = 3'd0,
    KIND_REG_READ  = 3'd1,
    KIND_DESC      = 3'd2,
    KIND_REQUEST   = 3'd3,
    KIND_IRQ       = 3'd4
  } in_kind_e;

  typedef enum logic [2:0] {
    RES_READ     = 3'd0,
    RES_SEGMENT  = 3'd1,
    RES_FETCH    = 3'd2,
    RES_REFUSED  = 3'd3,
    RES_DONE     = 3'd4,
    RES_UNDERRUN = 3'd5
  } res_kind_e;

  localparam logic [2:0] OffCommand = 3'd0;
  localparam logic [2:0] OffStatus  = 3'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  read_byte;
    logic [31:0] mem_address;
    logic [16:0] segment_length;
    logic [16:0] buffer_offset;
    logic        segment_to_memory;
    logic        channel;
  } result_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        channel;
    logic [2:0]  reg_offset;
    logic [7:0]  write_byte;
    logic [31:0] desc_address_word;
    logic [31:0] desc_count_word;
    logic [16:0] transfer_bytes;
    logic        to_memory;
  } item_t;

endpackage

// ===== rtl/ide_bus_master_dma_controller_top.sv =====
// top level of the two-channel bus-master ide dma controller
// depends on ibm_dma_pkg, ibm_dma_core, ibm_dma_outq
// each item is registered, processed in one combinational pass against the
// channel registers, and its zero to three results go to a small result buffer.
// the registered item is processed once the results before it have left the
// buffer, and a new item is taken into the input register in that same cycle,
// so results stream back to back at one per cycle while the receiver takes
// them. the memory size register may be written at any time the block is
// idle.
module ide_bus_master_dma_controller_top import ibm_dma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic        channel_i,
  input  logic [2:0]  reg_offset_i,
  input  logic [7:0]  write_byte_i,
  input  logic [31:0] desc_address_word_i,
  input  logic [31:0] desc_count_word_i,
  input  logic [16:0] transfer_bytes_i,
  input  logic        to_memory_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [22:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [7:0]  read_byte_o,
  output logic [31:0] mem_address_o,
  output logic [16:0] segment_length_o,
  output logic [16:0] buffer_offset_o,
  output logic        segment_to_memory_o,
  output logic        result_channel_o,
  output logic        last_o
);

  item_t         item_q;
  logic          full_q;
  logic [22:0]   mem_kb_q;
  logic          go, empty;
  result_t [2:0] res;
  logic [1:0]    n_res;
  result_t       r;

  // input register: one item waits here until the result buffer drains
  assign go         = full_q && empty;
  assign in_ready_o = !full_q || go;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q   <= 1'b0;
      mem_kb_q <= 23'd16384;
    end else begin
      if (in_ready_o) full_q <= in_valid_i;
      if (cfg_valid_i) mem_kb_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{kind_i, channel_i, reg_offset_i, write_byte_i, desc_address_word_i,
                  desc_count_word_i, transfer_bytes_i, to_memory_i};
    end
  end

  ibm_dma_core u_core (
    .clk_i, .rst_ni, .go_i(go), .item_i(item_q), .mem_kb_i(mem_kb_q),
    .res_o(res), .n_res_o(n_res)
  );

  ibm_dma_outq u_outq (
    .clk_i, .rst_ni, .load_i(go), .res_i(res), .n_res_i(n_res), .empty_o(empty),
    .valid_o(out_valid_o), .ready_i(out_ready_i), .res_o(r), .last_o(last_o)
  );

  assign result_kind_o       = r.kind;
  assign read_byte_o         = r.read_byte;
  assign mem_address_o       = r.mem_address;
  assign segment_length_o    = r.segment_length;
  assign buffer_offset_o     = r.buffer_offset;
  assign segment_to_memory_o = r.segment_to_memory;
  assign result_channel_o    = r.channel;

`ifndef NO_ASSERTIONS
  // the core never fires while results of the previous item remain
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |-> empty) else $error("core fired over pending results");
  // a held result stays put under back-pressure
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o))
    else $error("result changed while stalled");
  // a segment is never longer than the maximum transfer
  a_seg_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segment_length_o <= 17'(MaxTransfer))
    else $error("segment too long");
`endif

endmodule

// ===== rtl/ibm_dma_core.sv =====
// ibm_dma_core: per-channel register file and one-pass item processing
// depends on ibm_dma_pkg
module ibm_dma_core import ibm_dma_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  item_t         item_i,
  input  logic [22:0]   mem_kb_i,
  output result_t [2:0] res_o,
  output logic [1:0]    n_res_o
);

  logic [7:0]  cmd_q [NumChannels], cmd_d [NumChannels];
  logic [7:0]  sts_q [NumChannels], sts_d [NumChannels];
  logic [31:0] base_q [NumChannels], base_d [NumChannels];
  logic [31:0] cur_q [NumChannels], cur_d [NumChannels];
  logic [31:0] saddr_q [NumChannels], saddr_d [NumChannels];
  logic [16:0] scnt_q [NumChannels], scnt_d [NumChannels];
  logic        sfin_q [NumChannels], sfin_d [NumChannels];
  logic [16:0] prem_q [NumChannels], prem_d [NumChannels];
  logic [16:0] poff_q [NumChannels], poff_d [NumChannels];
  logic        pdir_q [NumChannels], pdir_d [NumChannels];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        cmd_q[i] <= '0; sts_q[i] <= '0; base_q[i] <= '0; cur_q[i] <= '0;
        saddr_q[i] <= '0; scnt_q[i] <= '0; sfin_q[i] <= 1'b0;
        prem_q[i] <= '0; poff_q[i] <= '0; pdir_q[i] <= 1'b0;
      end
    end else if (go_i) begin
      for (int i = 0; i < NumChannels; i++) begin
        cmd_q[i] <= cmd_d[i]; sts_q[i] <= sts_d[i]; base_q[i] <= base_d[i];
        cur_q[i] <= cur_d[i]; saddr_q[i] <= saddr_d[i]; scnt_q[i] <= scnt_d[i];
        sfin_q[i] <= sfin_d[i]; prem_q[i] <= prem_d[i]; poff_q[i] <= poff_d[i];
        pdir_q[i] <= pdir_d[i];
      end
    end
  end

  logic        c;
  logic [4:0]  sh;
  logic [16:0] rem, cnt, chunk, dcnt, bytes;
  logic [33:0] mem, aend;
  logic [31:0] addr;
  logic [16:0] len;
  logic        do_adv;
  logic [7:0]  rb;

  always_comb begin
    c = item_i.channel;
    for (int i = 0; i < NumChannels; i++) begin
      cmd_d[i] = cmd_q[i]; sts_d[i] = sts_q[i]; base_d[i] = base_q[i];
      cur_d[i] = cur_q[i]; saddr_d[i] = saddr_q[i]; scnt_d[i] = scnt_q[i];
      sfin_d[i] = sfin_q[i]; prem_d[i] = prem_q[i]; poff_d[i] = poff_q[i];
      pdir_d[i] = pdir_q[i];
    end
    res_o = '0;
    n_res_o = 2'd0;
    do_adv = 1'b0;
    sh = {item_i.reg_offset[1:0], 3'b000};
    rb = 8'hff;
    dcnt = {1'b0, item_i.desc_count_word[15:1], 1'b0};
    if (dcnt == 17'd0) dcnt = 17'h10000;
    bytes = (item_i.transfer_bytes > 17'(MaxTransfer)) ? 17'(MaxTransfer)
                                                       : item_i.transfer_bytes;
    unique case (item_i.kind)
      KIND_REG_WRITE: begin
        if (item_i.reg_offset == OffCommand) begin
          if (item_i.write_byte[0] && !cmd_q[c][0]) begin
            scnt_d[c] = '0; sfin_d[c] = 1'b0; prem_d[c] = '0; poff_d[c] = '0;
            sts_d[c][0] = 1'b1;
            res_o[0].kind = RES_FETCH;
            res_o[0].mem_address = base_q[c];
            res_o[0].channel = c;
            n_res_o = 2'd1;
            cur_d[c] = base_q[c] + 32'd8;
          end
          if (!item_i.write_byte[0] && cmd_q[c][0]) begin
            sts_d[c][0] = 1'b0; prem_d[c] = '0; poff_d[c] = '0;
          end
          cmd_d[c] = item_i.write_byte;
        end else if (item_i.reg_offset == OffStatus) begin
          sts_d[c] = (item_i.write_byte & 8'h60) | (sts_q[c] & ~item_i.write_byte & 8'h06)
                     | (sts_q[c] & 8'h01);
        end else if (item_i.reg_offset[2]) begin
          base_d[c] = (base_q[c] & ~(32'hff << sh)) | (32'(item_i.write_byte) << sh);
        end
      end
      KIND_REG_READ: begin
        if (item_i.reg_offset == OffCommand) rb = cmd_q[c];
        else if (item_i.reg_offset == OffStatus) rb = sts_q[c];
        else if (item_i.reg_offset[2]) rb = 8'(base_q[c] >> sh);
        res_o[0].kind = RES_READ;
        res_o[0].read_byte = rb;
        res_o[0].channel = c;
        n_res_o = 2'd1;
      end
      KIND_DESC: begin
        saddr_d[c] = {item_i.desc_address_word[31:1], 1'b0};
        scnt_d[c] = dcnt;
        sfin_d[c] = item_i.desc_count_word[31];
        do_adv = 1'b1;
      end
      KIND_REQUEST: begin
        if (!sts_q[c][0]) begin
          res_o[0].kind = RES_REFUSED;
          res_o[0].channel = c;
          n_res_o = 2'd1;
        end else begin
          prem_d[c] = bytes; poff_d[c] = '0; pdir_d[c] = item_i.to_memory;
          if (bytes == 17'd0) begin
            res_o[0].kind = RES_DONE;
            res_o[0].channel = c;
            n_res_o = 2'd1;
          end else do_adv = 1'b1;
        end
      end
      KIND_IRQ: sts_d[c][2] = 1'b1;
      default: ;
    endcase

    // advance over the updated channel state
    rem = prem_d[c];
    cnt = scnt_d[c];
    addr = saddr_d[c];
    chunk = (cnt < rem) ? cnt : rem;
    mem = {1'b0, mem_kb_i, 10'd0};
    aend = {2'b00, addr} + {17'd0, chunk};
    if ({2'b00, addr} >= mem) len = '0;
    else if (aend > mem) len = 17'(mem - {2'b00, addr});
    else len = chunk;
    if (do_adv && rem != 0 && cnt != 0 && sts_d[c][0]) begin
      if (sfin_d[c] && cnt < rem) begin
        res_o[0].kind = RES_UNDERRUN;
        res_o[0].channel = c;
        n_res_o = 2'd1;
        sts_d[c] = (sts_d[c] & 8'hfe) | 8'h02;
        prem_d[c] = '0; poff_d[c] = '0;
      end else begin
        res_o[0].kind = RES_SEGMENT;
        res_o[0].mem_address = addr;
        res_o[0].segment_length = len;
        res_o[0].buffer_offset = poff_d[c];
        res_o[0].segment_to_memory = pdir_d[c];
        res_o[0].channel = c;
        n_res_o = 2'd1;
        saddr_d[c] = addr + 32'(chunk);
        scnt_d[c] = cnt - chunk;
        prem_d[c] = rem - chunk;
        poff_d[c] = poff_d[c] + chunk;
        if (cnt == chunk) begin
          if (sfin_d[c]) sts_d[c][0] = 1'b0;
          else begin
            res_o[1].kind = RES_FETCH;
            res_o[1].mem_address = cur_q[c];
            res_o[1].channel = c;
            n_res_o = 2'd2;
            cur_d[c] = cur_q[c] + 32'd8;
          end
        end
        if (rem == chunk) begin
          poff_d[c] = '0;
          res_o[n_res_o].kind = RES_DONE;
          res_o[n_res_o].channel = c;
          n_res_o = n_res_o + 2'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/ibm_dma_outq.sv =====
// ibm_dma_outq: holds up to three results of one item and hands them out in order
// depends on ibm_dma_pkg
module ibm_dma_outq import ibm_dma_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  result_t [2:0] res_i,
  input  logic [1:0]    n_res_i,
  output logic          empty_o,
  output logic          valid_o,
  input  logic          ready_i,
  output result_t       res_o,
  output logic          last_o
);

  result_t [2:0] buf_q;
  logic [1:0]    cnt_q, idx_q;
  logic          pop;

  assign valid_o = cnt_q != 2'd0;
  assign pop     = valid_o && ready_i;
  assign last_o  = (idx_q + 2'd1) == cnt_q;
  assign empty_o = !valid_o || (pop && last_o);
  assign res_o   = buf_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= n_res_i;
      idx_q <= '0;
    end else if (pop) begin
      if (last_o) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= res_i;
  end

endmodule

// ===== tb/ibm_dma_checker.sv =====
// checker for the bus-master ide dma controller: predicts results per accepted item
// and compares them in order with the result channel; depends on ibm_dma_pkg
`timescale 1ns / 1ps
module ibm_dma_checker import ibm_dma_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  kind_i,
  input  logic        channel_i,
  input  logic [2:0]  reg_offset_i,
  input  logic [7:0]  write_byte_i,
  input  logic [31:0] desc_address_word_i,
  input  logic [31:0] desc_count_word_i,
  input  logic [16:0] transfer_bytes_i,
  input  logic        to_memory_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [22:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  result_kind_i,
  input  logic [7:0]  read_byte_i,
  input  logic [31:0] mem_address_i,
  input  logic [16:0] segment_length_i,
  input  logic [16:0] buffer_offset_i,
  input  logic        segment_to_memory_i,
  input  logic        result_channel_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [2:0] OffPointer = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  rb;
    logic [31:0] addr;
    logic [16:0] len;
    logic [16:0] off;
    logic        dir;
    logic        ch;
    logic        last;
  } dma_result_t;

  dma_result_t expected_q[$];
  dma_result_t batch_q[$];

  logic [22:0] mem_kb;
  logic [7:0]  cmd_r[2];
  logic [7:0]  stat_r[2];
  logic [31:0] base_r[2];
  logic [31:0] cursor_r[2];
  logic [31:0] seg_addr_r[2];
  logic [16:0] seg_cnt_r[2];
  logic        seg_final_r[2];
  logic [16:0] rem_r[2];
  logic [16:0] off_r[2];
  logic        dir_r[2];
  bit          bad;

  task automatic add_result(logic [2:0] k, logic [7:0] rb, logic [31:0] a, logic [16:0] l,
                            logic [16:0] o, logic d, logic c);
    dma_result_t r;
    r = '{kind: k, rb: rb, addr: a, len: l, off: o, dir: d, ch: c, last: 1'b0};
    batch_q.push_back(r);
  endtask

  task automatic add_fetch(int c);
    add_result(RES_FETCH, 8'h0, cursor_r[c], '0, '0, 1'b0, c[0]);
    cursor_r[c] = cursor_r[c] + 32'd8;
  endtask

  // move as much of the pending request as the current entry allows
  task automatic run_transfer(int c);
    logic [16:0] chunk, len;
    logic [33:0] mem_bytes, seg_end;
    if (rem_r[c] == 0 || seg_cnt_r[c] == 0 || !stat_r[c][0]) return;
    if (seg_final_r[c] && seg_cnt_r[c] < rem_r[c]) begin
      add_result(RES_UNDERRUN, 8'h0, '0, '0, '0, 1'b0, c[0]);
      stat_r[c][0] = 1'b0;
      stat_r[c][1] = 1'b1;
      rem_r[c] = '0;
      off_r[c] = '0;
      return;
    end
    chunk = (seg_cnt_r[c] < rem_r[c]) ? seg_cnt_r[c] : rem_r[c];
    mem_bytes = {1'b0, mem_kb, 10'b0};
    seg_end = {2'b0, seg_addr_r[c]} + {17'b0, chunk};
    if ({2'b0, seg_addr_r[c]} >= mem_bytes) len = '0;
    else if (seg_end > mem_bytes) len = 17'(mem_bytes - {2'b0, seg_addr_r[c]});
    else len = chunk;
    add_result(RES_SEGMENT, 8'h0, seg_addr_r[c], len, off_r[c], dir_r[c], c[0]);
    seg_addr_r[c] = seg_addr_r[c] + {15'b0, chunk};
    seg_cnt_r[c] = seg_cnt_r[c] - chunk;
    rem_r[c] = rem_r[c] - chunk;
    off_r[c] = off_r[c] + chunk;
    if (seg_cnt_r[c] == 0) begin
      if (seg_final_r[c]) stat_r[c][0] = 1'b0;
      else add_fetch(c);
    end
    if (rem_r[c] == 0) begin
      off_r[c] = '0;
      add_result(RES_DONE, 8'h0, '0, '0, '0, 1'b0, c[0]);
    end
  endtask

  task automatic predict_item();
    int c;
    logic [7:0] v, rb;
    logic [16:0] bytes;
    c = channel_i;
    v = write_byte_i;
    batch_q.delete();
    case (kind_i)
      KIND_REG_WRITE: begin
        if (reg_offset_i == OffCommand) begin
          if (v[0] && !cmd_r[c][0]) begin
            cursor_r[c] = base_r[c];
            seg_cnt_r[c] = '0;
            seg_final_r[c] = 1'b0;
            rem_r[c] = '0;
            off_r[c] = '0;
            stat_r[c][0] = 1'b1;
            add_fetch(c);
          end
          if (!v[0] && cmd_r[c][0]) begin
            stat_r[c][0] = 1'b0;
            rem_r[c] = '0;
            off_r[c] = '0;
          end
          cmd_r[c] = v;
        end else if (reg_offset_i == OffStatus) begin
          stat_r[c] = (v & 8'h60) | (stat_r[c] & ~v & 8'h06) | (stat_r[c] & 8'h01);
        end else if (reg_offset_i >= OffPointer) begin
          base_r[c][(reg_offset_i - OffPointer) * 8 +: 8] = v;
        end
      end
      KIND_REG_READ: begin
        rb = 8'hff;
        if (reg_offset_i == OffCommand) rb = cmd_r[c];
        else if (reg_offset_i == OffStatus) rb = stat_r[c];
        else if (reg_offset_i >= OffPointer) rb = base_r[c][(reg_offset_i - OffPointer) * 8 +: 8];
        add_result(RES_READ, rb, '0, '0, '0, 1'b0, c[0]);
      end
      KIND_DESC: begin
        seg_addr_r[c] = desc_address_word_i & ~32'd1;
        seg_cnt_r[c] = {1'b0, desc_count_word_i[15:1], 1'b0};
        if (seg_cnt_r[c] == 0) seg_cnt_r[c] = 17'h10000;
        seg_final_r[c] = desc_count_word_i[31];
        run_transfer(c);
      end
      KIND_REQUEST: begin
        if (!stat_r[c][0]) begin
          add_result(RES_REFUSED, 8'h0, '0, '0, '0, 1'b0, c[0]);
        end else begin
          bytes = (transfer_bytes_i > 17'(MaxTransfer)) ? 17'(MaxTransfer) : transfer_bytes_i;
          rem_r[c] = bytes;
          off_r[c] = '0;
          dir_r[c] = to_memory_i;
          if (bytes == 0) add_result(RES_DONE, 8'h0, '0, '0, '0, 1'b0, c[0]);
          else run_transfer(c);
        end
      end
      KIND_IRQ: stat_r[c][2] = 1'b1;
      default: ;
    endcase
    if (batch_q.size() > 0) batch_q[batch_q.size() - 1].last = 1'b1;
    foreach (batch_q[i]) expected_q.push_back(batch_q[i]);
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
      bad = 1'b1;
    end
  endtask

  task automatic check_result();
    dma_result_t e;
    if (expected_q.size() == 0) begin
      $display("%0t unexpected result: expected none actual kind %0d", $time, result_kind_i);
      fail_count_o++;
      return;
    end
    e = expected_q.pop_front();
    bad = 1'b0;
    check_field("result_kind", e.kind, result_kind_i);
    check_field("read_byte", e.rb, read_byte_i);
    check_field("mem_address", e.addr, mem_address_i);
    check_field("segment_length", e.len, segment_length_i);
    check_field("buffer_offset", e.off, buffer_offset_i);
    check_field("segment_to_memory", e.dir, segment_to_memory_i);
    check_field("result_channel", e.ch, result_channel_i);
    check_field("last", e.last, last_i);
    if (bad) fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_kb = 23'd16384;
      for (int i = 0; i < 2; i++) begin
        cmd_r[i] = '0; stat_r[i] = '0; base_r[i] = '0; cursor_r[i] = '0;
        seg_addr_r[i] = '0; seg_cnt_r[i] = '0; seg_final_r[i] = 1'b0;
        rem_r[i] = '0; off_r[i] = '0; dir_r[i] = 1'b0;
      end
      expected_q.delete();
      pending_o = 0;
    end else begin
      // results leave before any new item is predicted
      if (out_valid_i && out_ready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) mem_kb = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_item();
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// top of the testbench for the bus-master ide dma controller: clock, reset, stimulus
// and verdict; depends on ibm_dma_pkg, ibm_dma_checker and the block
`timescale 1ns / 1ps
module tb_top;
  import ibm_dma_pkg::*;

  localparam logic [2:0] OffPointer = 3'd4;
  localparam logic [2:0] OffUnmapLo = 3'd1;
  localparam logic [2:0] OffUnmapHi = 3'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  kind_i = '0;
  logic        channel_i = 1'b0;
  logic [2:0]  reg_offset_i = '0;
  logic [7:0]  write_byte_i = '0;
  logic [31:0] desc_address_word_i = '0;
  logic [31:0] desc_count_word_i = '0;
  logic [16:0] transfer_bytes_i = '0;
  logic        to_memory_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [22:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [7:0]  read_byte_o;
  logic [31:0] mem_address_o;
  logic [16:0] segment_length_o;
  logic [16:0] buffer_offset_o;
  logic        segment_to_memory_o;
  logic        result_channel_o;
  logic        last_o;

  int fail_count;
  int pending;
  bit idle_on = 1'b1;     // random gaps and stalls enabled
  logic [22:0] cur_kb = 23'd16384;

  always #4 clk_i = ~clk_i;

  ide_bus_master_dma_controller_top u_top (.*);

  ibm_dma_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .kind_i, .channel_i, .reg_offset_i, .write_byte_i,
    .desc_address_word_i, .desc_count_word_i, .transfer_bytes_i, .to_memory_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .result_kind_i(result_kind_o), .read_byte_i(read_byte_o), .mem_address_i(mem_address_o),
    .segment_length_i(segment_length_o), .buffer_offset_i(buffer_offset_o),
    .segment_to_memory_i(segment_to_memory_o), .result_channel_i(result_channel_o),
    .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side: a random stall, possibly none, before taking each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // hand one item over, valid held until the block takes it
  task automatic send(item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i <= it.kind;
    channel_i <= it.channel;
    reg_offset_i <= it.reg_offset;
    write_byte_i <= it.write_byte;
    desc_address_word_i <= it.desc_address_word;
    desc_count_word_i <= it.desc_count_word;
    transfer_bytes_i <= it.transfer_bytes;
    to_memory_i <= it.to_memory;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // zero default filler for the fields an item kind does not use
  function automatic item_t mk(logic [2:0] k, logic c, logic [2:0] o = 3'd0,
                               logic [7:0] b = 8'h0, logic [31:0] a = 32'h0,
                               logic [31:0] n = 32'h0, logic [16:0] t = 17'h0,
                               logic d = 1'b0);
    item_t it;
    it = '{kind: k, channel: c, reg_offset: o, write_byte: b, desc_address_word: a,
           desc_count_word: n, transfer_bytes: t, to_memory: d};
    return it;
  endfunction

  // wait until every expected result has come, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_mem_size(logic [22:0] kb);
    cfg_data_i <= kb;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_kb = kb;
  endtask

  function automatic logic [31:0] rand_addr();
    logic [33:0] mem;
    mem = {1'b0, cur_kb, 10'b0};
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h00ff_ffff);
      // straddle the end of installed memory
      2: return 32'(mem) - 32'($urandom_range(0, 4096));
      default: return 32'(mem) + 32'($urandom_range(0, 64));
    endcase
  endfunction

  function automatic logic [31:0] rand_count(bit fin);
    logic [31:0] w;
    w = $urandom();
    if ($urandom_range(0, 9) == 0) w[15:1] = '0;            // full 64k entry
    else if ($urandom_range(0, 3) != 0) w[15:0] = 16'($urandom_range(0, 4096));
    w[31] = fin;
    return w;
  endfunction

  function automatic logic [16:0] rand_bytes();
    case ($urandom_range(0, 7))
      0: return 17'($urandom_range(65536, 131071));         // saturates
      1: return 17'd0;
      2: return 17'($urandom_range(0, 65536));
      default: return 17'($urandom_range(1, 6000));
    endcase
  endfunction

  function automatic item_t noise_item();
    logic [2:0] k;
    k = 3'($urandom_range(0, 7));
    if (k == KIND_REG_WRITE && $urandom_range(0, 1)) return mk(k, 1'($urandom()), OffCommand,
                                                               8'($urandom()));
    return mk(k, 1'($urandom()), 3'($urandom()), 8'($urandom()), $urandom(), $urandom(),
              17'($urandom()), 1'($urandom()));
  endfunction

  // start a channel, maybe post a request and feed it descriptors; returns item count
  task automatic dma_sequence(output int cnt);
    logic c;
    int ndesc;
    bit fin;
    c = 1'($urandom());
    cnt = 0;
    if ($urandom_range(0, 2) == 0) begin
      for (int i = 0; i < 4; i++) begin
        send(mk(KIND_REG_WRITE, c, OffPointer + 3'(i), 8'($urandom())));
        cnt++;
      end
    end
    send(mk(KIND_REG_WRITE, c, OffCommand, 8'($urandom()) & 8'hfe)); cnt++;
    send(mk(KIND_REG_WRITE, c, OffCommand, 8'($urandom()) | 8'h01)); cnt++;
    if ($urandom_range(0, 1)) begin
      send(mk(KIND_REQUEST, c, 3'd0, 8'h0, 32'h0, 32'h0, rand_bytes(), 1'($urandom())));
      cnt++;
    end
    ndesc = $urandom_range(1, 4);
    for (int i = 0; i < ndesc; i++) begin
      fin = (i == ndesc - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
      send(mk(KIND_DESC, c, 3'd0, 8'h0, rand_addr(), rand_count(fin)));
      cnt++;
      if ($urandom_range(0, 2) == 0) begin
        send(mk(KIND_REQUEST, c, 3'd0, 8'h0, 32'h0, 32'h0, rand_bytes(), 1'($urandom())));
        cnt++;
      end
      if ($urandom_range(0, 4) == 0) begin
        send(noise_item());
        cnt++;
      end
    end
    send(mk(KIND_REG_READ, c, OffStatus)); cnt++;
    if ($urandom_range(0, 3) == 0) begin
      send(mk(KIND_REG_WRITE, c, OffStatus, 8'($urandom()))); cnt++;
    end
  endtask

  task automatic random_phase(int items);
    int n, k;
    n = 0;
    while (n < items) begin
      if ($urandom_range(0, 4) == 0) begin
        send(noise_item());
        n++;
      end else begin
        dma_sequence(k);
        n += k;
      end
    end
  endtask

  task automatic directed();
    send(mk(KIND_REQUEST, 1'b0, 3'd0, 8'h0, 32'h0, 32'h0, 17'd64, 1'b1));  // refused, inactive
    send(mk(KIND_REG_WRITE, 1'b0, OffPointer, 8'hff));
    send(mk(KIND_REG_WRITE, 1'b0, OffPointer + 3'd1, 8'h00));
    send(mk(KIND_REG_WRITE, 1'b0, OffPointer + 3'd2, 8'ha5));
    send(mk(KIND_REG_WRITE, 1'b0, OffPointer + 3'd3, 8'h5a));
    send(mk(KIND_REG_WRITE, 1'b0, OffUnmapLo, 8'hff));                    // ignored
    send(mk(KIND_REG_READ, 1'b0, OffUnmapHi));
    send(mk(KIND_REG_READ, 1'b0, OffPointer + 3'd3));
    send(mk(KIND_REG_WRITE, 1'b0, OffCommand, 8'h01));                    // start
    // entry of 64k at an odd address, nothing pending yet
    send(mk(KIND_DESC, 1'b0, 3'd0, 8'h0, 32'h0000_1001, 32'h0000_0001));
    send(mk(KIND_REQUEST, 1'b0, 3'd0, 8'h0, 32'h0, 32'h0, 17'h1ffff, 1'b1)); // oversized
    send(mk(KIND_REQUEST, 1'b0, 3'd0, 8'h0, 32'h0, 32'h0, 17'd0, 1'b0));    // zero bytes
    send(mk(KIND_REQUEST, 1'b0, 3'd0, 8'h0, 32'h0, 32'h0, 17'd100, 1'b0));  // waits
    send(mk(KIND_DESC, 1'b0, 3'd0, 8'h0, 32'hffff_ffff, 32'h8000_000a));    // underrun
    send(mk(KIND_IRQ, 1'b0));
    send(mk(KIND_REG_READ, 1'b0, OffStatus));
    send(mk(KIND_REG_WRITE, 1'b0, OffStatus, 8'hff));
    send(mk(KIND_REG_READ, 1'b0, OffStatus));
    send(mk(KIND_REG_WRITE, 1'b0, OffCommand, 8'h00));                    // stop
    send(mk(KIND_REG_WRITE, 1'b1, OffCommand, 8'hff));
    // final entry past installed memory: zero-length segment
    send(mk(KIND_DESC, 1'b1, 3'd0, 8'h0, 32'hffff_fffe, 32'h8000_fffe));
    send(mk(KIND_REQUEST, 1'b1, 3'd0, 8'h0, 32'h0, 32'h0, 17'd16, 1'b1));
    send(mk(3'd5, 1'b1, 3'd7, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 17'h1ffff, 1'b1));
    send(mk(KIND_REG_READ, 1'b1, OffCommand));
  endtask

  initial begin
    logic [22:0] sizes [5];
    sizes = '{23'd16384, 23'd0, 23'd4194304, 23'd1, 23'($urandom_range(0, 4194304))};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    drain();
    for (int p = 0; p < 5; p++) begin
      write_mem_size(sizes[p]);
      idle_on = (p != 2);   // one phase runs back to back
      random_phase(88);
      drain();
    end
    idle_on = 1'b1;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
